>>> hdl/dpd_pkg.sv
// Package for the dual packet deframer: shared types and fixed constants.
// Used by every module of the block through scoped names.
`default_nettype none

package dpd_pkg;

    // window store geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned FILL_W = 6;
    localparam logic [FILL_W-1:0] WIN_DEPTH   = 6'd32;
    localparam logic [FILL_W-1:0] SENSOR_LEN  = 6'd32;
    localparam logic [FILL_W-1:0] TRIGGER_LEN = 6'd12;
    localparam logic [FILL_W-1:0] MIN_HOLD    = 6'd2;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // header register resets
    localparam logic [15:0] SENSOR_HDR_RST  = 16'hAA55;
    localparam logic [15:0] TRIGGER_HDR_RST = 16'hBB66;

    // configuration register indexes
    localparam logic REG_SENSOR_HDR  = 1'b0;
    localparam logic REG_TRIGGER_HDR = 1'b1;

    // packet kinds
    localparam logic KIND_SENSOR  = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    // one result word
    typedef struct packed {
        logic        kind;
        logic [31:0] stamp_us;
        logic [15:0] frame_number;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_z;
        logic [31:0] gyro_x;
        logic [31:0] gyro_y;
        logic [31:0] gyro_z;
        logic [15:0] reject_total;
        logic        last;
    } t_result;

    // commands from the sequencer to the result buffer
    typedef struct packed {
        logic load;   // capture a new result into the pending slot
        logic push;   // move the pending slot to the output register
        logic last;   // last flag given to the pushed word
    } t_ob_cmd;

endpackage

`default_nettype wire

>>> hdl/dpd_window.sv
// Window store of the deframer: 32 x 8 synchronous memory, one write and
// one read port, read data registered. Depends on dpd_pkg.
`default_nettype none

module dpd_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [dpd_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]                 i_wdata,
    input  wire logic [dpd_pkg::ADDR_W-1:0] i_raddr,
    output logic      [7:0]                 o_rdata
);

    logic [7:0] r_mem [2**dpd_pkg::ADDR_W];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/dpd_crc.sv
// CRC-16/MODBUS unit of the deframer: one byte per cycle while enabled, reflected form.
// Depends on dpd_pkg for the initial value and polynomial.
`default_nettype none

module dpd_crc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_init,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // fold one byte into the running value, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ dpd_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // next value
    always_comb begin
        n_crc = r_crc;
        if (i_init) begin
            n_crc = dpd_pkg::CRC_INIT;
        end else if (i_en) begin
            n_crc = crc_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= dpd_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

>>> hdl/dpd_outbuf.sv
// Result buffer of the deframer: a pending slot that waits for its last
// flag, and the output register of the result channel. Depends on dpd_pkg.
`default_nettype none

module dpd_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dpd_pkg::t_ob_cmd i_cmd,
    input  wire dpd_pkg::t_result i_new,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output dpd_pkg::t_result      o_data,
    output logic                  o_free
);

    dpd_pkg::t_result r_pend;
    dpd_pkg::t_result r_out;
    dpd_pkg::t_result n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    // output slot frees when empty or taken this cycle
    assign o_free = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // pushed word: the pending slot with the last flag of this push
    always_comb begin
        n_out      = r_pend;
        n_out.last = i_cmd.last;
    end

    // payload: push reads the old pending word, load replaces it
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= n_out;
        end
        if (i_cmd.load) begin
            r_pend <= i_new;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/dual_packet_deframer_crc16.sv
// Dual packet deframer with CRC-16/MODBUS check, top level; one byte in flight at a time.
// Per byte: accept, check, two header reads while a header waits at the front; accept and
// check with under two bytes held. Each byte dropped and each packet removed adds a recheck
// (check only if under two bytes remain). A packet adds a scan, plus an emit if good.
// Results leave the cycle after their push; the last of a byte waits in a flush step for
// a free output register. Sync reset clears control and counters and presets the headers.
`default_nettype none

module dual_packet_deframer_crc16 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    // received bytes
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    // packet results
    output logic             o_pkt_valid,
    input  wire logic        i_pkt_ready,
    output logic             o_packet_kind,
    output logic [31:0]      o_stamp_us,
    output logic [15:0]      o_frame_number,
    output logic [31:0]      o_accel_x_bits,
    output logic [31:0]      o_accel_y_bits,
    output logic [31:0]      o_accel_z_bits,
    output logic [31:0]      o_gyro_x_bits,
    output logic [31:0]      o_gyro_y_bits,
    output logic [31:0]      o_gyro_z_bits,
    output logic [15:0]      o_reject_total,
    output logic             o_last_of_run
);

    localparam int unsigned AW = dpd_pkg::ADDR_W;
    localparam int unsigned FW = dpd_pkg::FILL_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_HDR_LO = 6'b000100,
        S_HDR_HI = 6'b001000,
        S_SCAN   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head,  n_head;
    logic [FW-1:0]   r_fill,  n_fill;
    logic [AW-1:0]   r_idx,   n_idx;
    logic            r_kind,  n_kind;
    logic [1:0]      r_count, n_count;
    logic [15:0]     r_rej,   n_rej;
    logic [15:0]     r_sens_hdr;
    logic [15:0]     r_trig_hdr;
    logic [7:0]      r_hdr_lo;
    logic [7:0]      r_exp_lo;
    logic [27:0][7:0] r_body;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    logic [7:0]      w_rdata;
    logic            w_crc_init;
    logic            w_crc_en;
    logic [15:0]     w_crc;
    logic [15:0]     w_hdr;
    logic            w_is_s;
    logic            w_is_t;
    logic [FW-1:0]   w_len;
    logic [AW-1:0]   w_last_idx;
    logic [AW-1:0]   w_crc_end;
    logic [AW-1:0]   w_bidx;
    logic            w_ob_free;
    dpd_pkg::t_ob_cmd w_ob_cmd;
    dpd_pkg::t_result w_new;
    dpd_pkg::t_result w_out;

    // packet geometry for the kind in hand
    assign w_len      = (r_kind == dpd_pkg::KIND_TRIGGER) ? dpd_pkg::TRIGGER_LEN
                                                          : dpd_pkg::SENSOR_LEN;
    assign w_last_idx = AW'(w_len - FW'(1));
    assign w_crc_end  = AW'(w_len - FW'(2));
    assign w_bidx     = AW'(r_idx - AW'(2));
    assign w_hdr      = {w_rdata, r_hdr_lo};
    assign w_is_s     = (w_hdr == r_sens_hdr);
    assign w_is_t     = (w_hdr == r_trig_hdr);

    assign o_rx_ready = (r_state == S_IDLE) && (r_count == 2'd0);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_kind     = r_kind;
        n_count    = r_count;
        n_rej      = r_rej;
        w_we       = 1'b0;
        w_waddr    = AW'(r_head + r_fill[AW-1:0]);
        w_raddr    = r_head;
        w_crc_init = 1'b0;
        w_crc_en   = 1'b0;
        w_ob_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_count != 2'd0) begin
                    // flush the final result of the run
                    if (w_ob_free) begin
                        w_ob_cmd.push = 1'b1;
                        w_ob_cmd.last = 1'b1;
                        n_count       = 2'd0;
                    end
                end else if (i_rx_valid) begin
                    // append the byte, dropping the oldest if full
                    w_we = 1'b1;
                    if (r_fill == dpd_pkg::WIN_DEPTH) begin
                        n_head = AW'(r_head + AW'(1));
                    end else begin
                        n_fill = FW'(r_fill + FW'(1));
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_fill < dpd_pkg::MIN_HOLD) begin
                    n_state = S_IDLE;
                end else begin
                    w_raddr = r_head;
                    n_state = S_HDR_LO;
                end
            end
            S_HDR_LO: begin
                w_raddr = AW'(r_head + AW'(1));
                n_state = S_HDR_HI;
            end
            S_HDR_HI: begin
                priority if (w_is_s && r_fill >= dpd_pkg::SENSOR_LEN) begin
                    n_kind     = dpd_pkg::KIND_SENSOR;
                    n_idx      = '0;
                    w_raddr    = r_head;
                    w_crc_init = 1'b1;
                    n_state    = S_SCAN;
                end else if (w_is_t && r_fill >= dpd_pkg::TRIGGER_LEN) begin
                    n_kind     = dpd_pkg::KIND_TRIGGER;
                    n_idx      = '0;
                    w_raddr    = r_head;
                    w_crc_init = 1'b1;
                    n_state    = S_SCAN;
                end else if (w_is_s || w_is_t) begin
                    // wait for the rest of the packet
                    n_state = S_IDLE;
                end else begin
                    // no header at the front: drop one byte
                    n_head  = AW'(r_head + AW'(1));
                    n_fill  = FW'(r_fill - FW'(1));
                    n_state = S_CHECK;
                end
            end
            S_SCAN: begin
                w_raddr  = AW'(r_head + r_idx + AW'(1));
                n_idx    = AW'(r_idx + AW'(1));
                w_crc_en = (r_idx < w_crc_end);
                if (r_idx == w_last_idx) begin
                    if (w_crc == {w_rdata, r_exp_lo}) begin
                        n_state = S_EMIT;
                    end else begin
                        // bad packet: count it, drop its first byte, hunt again
                        if (r_rej != 16'hFFFF) begin
                            n_rej = r_rej + 16'd1;
                        end
                        n_head  = AW'(r_head + AW'(1));
                        n_fill  = FW'(r_fill - FW'(1));
                        n_state = S_CHECK;
                    end
                end
            end
            S_EMIT: begin
                unique case (r_count)
                    2'd0: begin
                        w_ob_cmd.load = 1'b1;
                        n_count       = 2'd1;
                        n_head        = AW'(r_head + w_len[AW-1:0]);
                        n_fill        = FW'(r_fill - w_len);
                        n_state       = S_CHECK;
                    end
                    2'd1: begin
                        // the earlier result is not the last: release it first
                        if (w_ob_free) begin
                            w_ob_cmd.push = 1'b1;
                            w_ob_cmd.last = 1'b0;
                            w_ob_cmd.load = 1'b1;
                            n_count       = 2'd2;
                            n_head        = AW'(r_head + w_len[AW-1:0]);
                            n_fill        = FW'(r_fill - w_len);
                            n_state       = S_CHECK;
                        end
                    end
                    default: begin
                        // result quota used up: drop the packet silently
                        n_head  = AW'(r_head + w_len[AW-1:0]);
                        n_fill  = FW'(r_fill - w_len);
                        n_state = S_CHECK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_kind  <= dpd_pkg::KIND_SENSOR;
            r_count <= 2'd0;
            r_rej   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_kind  <= n_kind;
            r_count <= n_count;
            r_rej   <= n_rej;
        end
    end

    // header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_hdr <= dpd_pkg::SENSOR_HDR_RST;
            r_trig_hdr <= dpd_pkg::TRIGGER_HDR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dpd_pkg::REG_SENSOR_HDR:  r_sens_hdr <= i_cfg_data;
                dpd_pkg::REG_TRIGGER_HDR: r_trig_hdr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // capture header low byte, expected CRC low byte and packet body
    always_ff @(posedge i_clk) begin
        if (r_state == S_HDR_LO) begin
            r_hdr_lo <= w_rdata;
        end
        if (r_state == S_SCAN) begin
            if (r_idx == w_crc_end) begin
                r_exp_lo <= w_rdata;
            end
            if (r_idx >= AW'(2) && r_idx <= AW'(29)) begin
                r_body[w_bidx] <= w_rdata;
            end
        end
    end

    // assemble the result word from the captured body
    always_comb begin
        w_new              = '0;
        w_new.kind         = r_kind;
        w_new.stamp_us     = r_body[3:0];
        w_new.reject_total = r_rej;
        if (r_kind == dpd_pkg::KIND_TRIGGER) begin
            w_new.frame_number = r_body[5:4];
        end else begin
            w_new.accel_x = r_body[7:4];
            w_new.accel_y = r_body[11:8];
            w_new.accel_z = r_body[15:12];
            w_new.gyro_x  = r_body[19:16];
            w_new.gyro_y  = r_body[23:20];
            w_new.gyro_z  = r_body[27:24];
        end
    end

    dpd_window u_window (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dpd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (w_crc_init),
        .i_en    (w_crc_en),
        .i_byte  (w_rdata),
        .o_crc   (w_crc)
    );

    dpd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ob_cmd),
        .i_new   (w_new),
        .i_ready (i_pkt_ready),
        .o_valid (o_pkt_valid),
        .o_data  (w_out),
        .o_free  (w_ob_free)
    );

    assign o_packet_kind  = w_out.kind;
    assign o_stamp_us     = w_out.stamp_us;
    assign o_frame_number = w_out.frame_number;
    assign o_accel_x_bits = w_out.accel_x;
    assign o_accel_y_bits = w_out.accel_y;
    assign o_accel_z_bits = w_out.accel_z;
    assign o_gyro_x_bits  = w_out.gyro_x;
    assign o_gyro_y_bits  = w_out.gyro_y;
    assign o_gyro_z_bits  = w_out.gyro_z;
    assign o_reject_total = w_out.reject_total;
    assign o_last_of_run  = w_out.last;

    // window never holds more than its depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= dpd_pkg::WIN_DEPTH)
        else $error("window fill above depth");

    // an accepted byte is always checked against the front of the window
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rx_valid && o_rx_ready) |=> (r_state == S_CHECK))
        else $error("accepted byte not followed by front check");

    // a packet is emitted only when the window holds all of it
    a_emit_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_fill >= w_len))
        else $error("packet emitted from a short window");

    // reject counter never goes down
    a_rej_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_rej >= $past(r_rej)))
        else $error("reject counter decreased");

    // scan index stays within the packet
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= w_last_idx))
        else $error("scan index past packet end");

endmodule

`default_nettype wire

>>> tb/dpd_tb_pkg.sv
// Scoreboard for the dual packet deframer testbench: a byte-level predictor of
// the packet words and the queue of words still due. Depends on dpd_pkg.
`timescale 1ns / 100ps

package dpd_tb_pkg;

    import dpd_pkg::*;

    typedef enum logic [1:0] {HUNTING, WAIT_SENSOR, WAIT_TRIGGER} t_hunt;

    // CRC-16/MODBUS over the first n bytes of a frame
    function automatic logic [15:0] modbus_crc(input logic [7:0] data [32], input int n);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            crc = crc ^ {8'h00, data[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    class packet_board;

        logic [15:0] sensor_hdr;
        logic [15:0] trigger_hdr;
        logic [15:0] rejects;
        logic [7:0]  win [32];
        int unsigned held;
        t_hunt       hunt;
        t_result     due_packets [$];
        int unsigned bytes_seen;
        int unsigned packets_checked;
        int unsigned mismatches;

        function new();
            sensor_hdr      = SENSOR_HDR_RST;
            trigger_hdr     = TRIGGER_HDR_RST;
            rejects         = '0;
            held            = 0;
            hunt            = HUNTING;
            bytes_seen      = 0;
            packets_checked = 0;
            mismatches      = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void set_header(logic idx, logic [15:0] value);
            if (idx == REG_SENSOR_HDR) begin
                sensor_hdr = value;
            end else begin
                trigger_hdr = value;
            end
        endfunction

        // drop the n oldest bytes of the window
        function void shift_out(int unsigned n);
            if (n >= held) begin
                held = 0;
            end else begin
                for (int unsigned i = 0; i < held - n; i++) win[i] = win[i + n];
                held = held - n;
            end
        endfunction

        function logic [31:0] word32(int unsigned at);
            return {win[at + 3], win[at + 2], win[at + 1], win[at]};
        endfunction

        // unpack a verified packet at the front of the window
        function t_result unpack(int unsigned plen);
            t_result r;
            r = '0;
            r.stamp_us = word32(2);
            if (plen == SENSOR_LEN) begin
                r.kind    = KIND_SENSOR;
                r.accel_x = word32(6);
                r.accel_y = word32(10);
                r.accel_z = word32(14);
                r.gyro_x  = word32(18);
                r.gyro_y  = word32(22);
                r.gyro_z  = word32(26);
            end else begin
                r.kind         = KIND_TRIGGER;
                r.frame_number = {win[7], win[6]};
            end
            r.reject_total = rejects;
            return r;
        endfunction

        // append one accepted byte and hunt until the window needs more bytes
        function void note_byte(logic [7:0] b);
            t_result     made [$];
            logic [15:0] head;
            int unsigned plen;
            logic        s_hit;
            logic        t_hit;
            bytes_seen++;
            if (held >= WIN_DEPTH) shift_out(1);
            win[held] = b;
            held++;
            while (held >= MIN_HOLD) begin
                head  = {win[1], win[0]};
                s_hit = (head == sensor_hdr);
                t_hit = (head == trigger_hdr);
                plen  = 0;
                if (s_hit && held >= SENSOR_LEN) begin
                    plen = 32'(SENSOR_LEN);
                end else if (t_hit && held >= TRIGGER_LEN) begin
                    plen = 32'(TRIGGER_LEN);
                end
                if (plen == 0) begin
                    // hold on a known header, drop anything else
                    if (s_hit || t_hit) begin
                        hunt = s_hit ? WAIT_SENSOR : WAIT_TRIGGER;
                        break;
                    end
                    shift_out(1);
                    continue;
                end
                // bad CRC: count it and rehunt from the next byte
                if (modbus_crc(win, plen - 2) != {win[plen - 1], win[plen - 2]}) begin
                    if (rejects != 16'hFFFF) rejects++;
                    shift_out(1);
                    continue;
                end
                if (made.size() < 2) made = {made, unpack(plen)};
                shift_out(plen);
            end
            if (held < MIN_HOLD) hunt = HUNTING;
            if (made.size() > 0) made[made.size() - 1].last = 1'b1;
            foreach (made[i]) due_packets = {due_packets, made[i]};
        endfunction

        function void match(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted packet word with the oldest one due
        function void check_packet(t_result got);
            t_result want;
            if (due_packets.size() == 0) begin
                $error("packet word with nothing due: kind %0d stamp 0x%0h",
                       got.kind, got.stamp_us);
                mismatches++;
                return;
            end
            want = due_packets.pop_front();
            packets_checked++;
            match("packet_kind",  want.kind,         got.kind);
            match("stamp_us",     want.stamp_us,     got.stamp_us);
            match("frame_number", want.frame_number, got.frame_number);
            match("accel_x_bits", want.accel_x,      got.accel_x);
            match("accel_y_bits", want.accel_y,      got.accel_y);
            match("accel_z_bits", want.accel_z,      got.accel_z);
            match("gyro_x_bits",  want.gyro_x,       got.gyro_x);
            match("gyro_y_bits",  want.gyro_y,       got.gyro_y);
            match("gyro_z_bits",  want.gyro_z,       got.gyro_z);
            match("reject_total", want.reject_total, got.reject_total);
            match("last_of_run",  want.last,         got.last);
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
// Top of the dual packet deframer testbench: clock, reset, byte and packet
// handshakes, header writes and the run sequence. Depends on dpd_pkg and dpd_tb_pkg.
`timescale 1ns / 100ps

module tb_top;

    import dpd_pkg::*;
    import dpd_tb_pkg::*;

    localparam int BYTE_TARGET   = 1430;
    localparam int PHASE_BYTES   = 286;
    localparam int SETTLE_CYCLES = 1500;
    localparam int STALL_LIMIT   = 20000;
    localparam int IDLE_PCT      = 23;
    localparam int FLOOD_BYTES   = 46;

    typedef enum int {PAT_RANDOM, PAT_ONES, PAT_ZEROS} t_fill;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = REG_SENSOR_HDR;
    logic [15:0] i_cfg_data = '0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte  = '0;
    logic        o_pkt_valid;
    logic        i_pkt_ready = 1'b0;
    logic        o_packet_kind;
    logic [31:0] o_stamp_us;
    logic [15:0] o_frame_number;
    logic [31:0] o_accel_x_bits;
    logic [31:0] o_accel_y_bits;
    logic [31:0] o_accel_z_bits;
    logic [31:0] o_gyro_x_bits;
    logic [31:0] o_gyro_y_bits;
    logic [31:0] o_gyro_z_bits;
    logic [15:0] o_reject_total;
    logic        o_last_of_run;

    t_result     pkt_word;
    packet_board board;
    logic        steady = 1'b0;
    logic [7:0]  frame_buf [32];
    int          frame_len;
    int          stall_cycles = 0;

    dual_packet_deframer_crc16 u_dut (.*);

    assign pkt_word = {o_packet_kind, o_stamp_us, o_frame_number,
                       o_accel_x_bits, o_accel_y_bits, o_accel_z_bits,
                       o_gyro_x_bits, o_gyro_y_bits, o_gyro_z_bits,
                       o_reject_total, o_last_of_run};

    always #1 i_clk = ~i_clk;

    // stall the packet side at random, never in a steady stretch
    always @(negedge i_clk) begin
        i_pkt_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // check packet words and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_pkt_valid && i_pkt_ready) board.check_packet(pkt_word);
            if ((o_pkt_valid && i_pkt_ready) || (i_rx_valid && o_rx_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // offer one byte, idling at random first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_rx_valid = 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_rx_ready);
        board.note_byte(b);
    endtask

    // wait out every due packet and any replay still in flight
    task automatic settle();
        @(negedge i_clk);
        i_rx_valid = 1'b0;
        while (board.due_packets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_header(idx, value);
    endtask

    // build a well-formed frame under the current headers
    task automatic build_frame(input logic kind, input t_fill pattern);
        logic [15:0] head;
        logic [15:0] crc;
        head      = (kind == KIND_SENSOR) ? board.sensor_hdr : board.trigger_hdr;
        frame_len = (kind == KIND_SENSOR) ? int'(SENSOR_LEN) : int'(TRIGGER_LEN);
        frame_buf[0] = head[7:0];
        frame_buf[1] = head[15:8];
        for (int i = 2; i < frame_len - 2; i++) begin
            case (pattern)
                PAT_ONES:  frame_buf[i] = 8'hFF;
                PAT_ZEROS: frame_buf[i] = 8'h00;
                default:   frame_buf[i] = 8'($urandom_range(255));
            endcase
        end
        crc = modbus_crc(frame_buf, frame_len - 2);
        frame_buf[frame_len - 2] = crc[7:0];
        frame_buf[frame_len - 1] = crc[15:8];
    endtask

    // damage one bit past the header
    task automatic flip_bit();
        int at;
        at = int'($urandom_range(frame_len - 1, 2));
        frame_buf[at] = frame_buf[at] ^ (8'h01 << $urandom_range(7));
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++) send_byte(frame_buf[i]);
    endtask

    // one random sequence: mostly good frames, some damaged, cut or noise
    task automatic random_burst();
        int   pick;
        logic kind;
        pick = int'($urandom_range(99));
        kind = 1'($urandom_range(1));
        if (pick < 50) begin
            build_frame(kind, PAT_RANDOM);
            send_frame(frame_len);
        end else if (pick < 62) begin
            build_frame(kind, PAT_RANDOM);
            flip_bit();
            send_frame(frame_len);
        end else if (pick < 72) begin
            build_frame(kind, PAT_RANDOM);
            send_frame(int'($urandom_range(frame_len - 1, 2)));
        end else if (pick < 80) begin
            // a stray sensor header swallows two trigger frames until its CRC fails
            send_byte(board.sensor_hdr[7:0]);
            send_byte(board.sensor_hdr[15:8]);
            repeat (2) begin
                build_frame(KIND_TRIGGER, PAT_RANDOM);
                send_frame(frame_len);
            end
            repeat (6) send_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic fill_to(input int total);
        while (board.bytes_seen < total) random_burst();
    endtask

    initial begin
        logic [15:0] shared;
        board = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: byte extremes, a full-scale trigger and a damaged one
        send_byte(8'h00);
        send_byte(8'hFF);
        build_frame(KIND_TRIGGER, PAT_ONES);
        send_frame(frame_len);
        build_frame(KIND_TRIGGER, PAT_ZEROS);
        flip_bit();
        send_frame(frame_len);
        fill_to(PHASE_BYTES);

        // header extremes, each opened with a sensor frame of all ones or all zeros
        settle();
        write_header(REG_SENSOR_HDR, 16'h0000);
        write_header(REG_TRIGGER_HDR, 16'hFFFF);
        build_frame(KIND_SENSOR, PAT_ONES);
        send_frame(frame_len);
        fill_to(2 * PHASE_BYTES);

        settle();
        write_header(REG_SENSOR_HDR, 16'hFFFF);
        write_header(REG_TRIGGER_HDR, 16'h0000);
        build_frame(KIND_SENSOR, PAT_ZEROS);
        send_frame(frame_len);
        fill_to(3 * PHASE_BYTES);

        // both kinds share one header
        settle();
        shared = 16'($urandom_range(65535));
        write_header(REG_SENSOR_HDR, shared);
        write_header(REG_TRIGGER_HDR, shared);
        fill_to(4 * PHASE_BYTES);

        // random headers, no idling on either side
        settle();
        write_header(REG_SENSOR_HDR, 16'($urandom_range(65535)));
        write_header(REG_TRIGGER_HDR, 16'($urandom_range(65535)));
        steady = 1'b1;
        fill_to(BYTE_TARGET);
        steady = 1'b0;

        // zero flood under a zero trigger header: one reject per byte once a trigger length is held
        settle();
        write_header(REG_SENSOR_HDR, SENSOR_HDR_RST);
        write_header(REG_TRIGGER_HDR, 16'h0000);
        steady = 1'b1;
        repeat (FLOOD_BYTES) send_byte(8'h00);
        repeat (20) send_byte(8'h00);
        build_frame(KIND_TRIGGER, PAT_RANDOM);
        send_frame(frame_len);
        repeat (30) send_byte(8'h00);
        build_frame(KIND_TRIGGER, PAT_RANDOM);
        send_frame(frame_len);
        steady = 1'b0;

        settle();
        $display("Covered %0d bytes over six header settings; %0d packet words compared",
                 board.bytes_seen, board.packets_checked);
        $display("Reject counter reached %0d, including a run of zero-byte rejects",
                 board.rejects);
        if (board.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
